### rtl/core/sbst_pkg.sv
package sbst_pkg;

   localparam int unsigned AXES      = 3;
   localparam int unsigned DIV_STEPS = 17;
   localparam int unsigned STAGES    = DIV_STEPS + 2;
   localparam int unsigned FRAC_W    = 17;
   localparam int unsigned Q_W       = 19;
   localparam int unsigned NUM_W     = 34;
   localparam int unsigned DEN_W     = 33;

   localparam logic signed [Q_W-1:0]  Q_NEG_SAT = -19'sd1;
   localparam logic signed [Q_W-1:0]  Q_POS_SAT = 19'sd65537;
   localparam logic signed [Q_W-1:0]  Q_ZERO    = 19'sd0;
   localparam logic signed [Q_W-1:0]  Q_ONE     = 19'sd65536;
   localparam logic [FRAC_W-1:0]      FRAC_ONE  = 17'h10000;

   typedef struct packed {
      logic                  zero;
      logic                  in_slab;
      logic signed [Q_W-1:0] qa;
      logic signed [Q_W-1:0] qb;
   } axis_res_type;

endpackage

### rtl/core/sbst_div.sv
module sbst_div (
   input  logic                                  clock,
   input  logic [sbst_pkg::DIV_STEPS-1:0]        en,
   input  logic signed [sbst_pkg::NUM_W-1:0]     num,
   input  logic [sbst_pkg::DEN_W-1:0]            den,
   output logic signed [sbst_pkg::Q_W-1:0]       quot
);

   localparam int unsigned S  = sbst_pkg::DIV_STEPS;
   localparam int unsigned NW = sbst_pkg::NUM_W;
   localparam int unsigned DW = sbst_pkg::DEN_W;
   localparam int unsigned FW = sbst_pkg::FRAC_W;

   logic [NW-1:0] rem_ff [S];
   logic [DW-1:0] den_ff [S];
   logic [FW-1:0] q_ff   [S];
   logic          neg_ff [S];
   logic          big_ff [S];

   for (genvar k = 0; k < S; k++) begin : g_step
      logic [NW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [FW-1:0] q_prev;
      logic          neg_prev;
      logic          big_prev;
      logic [NW-1:0] trial;
      logic          take;
      logic [NW-1:0] rem_in;
      logic [FW-1:0] q_in;

      if (k == 0) begin : g_first
         always_comb begin
            rem_prev = num;
            den_prev = den;
            q_prev   = '0;
            neg_prev = num[NW-1];
            big_prev = {1'b0, num} >= {1'b0, den, 1'b0};
            trial    = rem_prev;
         end
      end else begin : g_next
         always_comb begin
            rem_prev = rem_ff[k-1];
            den_prev = den_ff[k-1];
            q_prev   = q_ff[k-1];
            neg_prev = neg_ff[k-1];
            big_prev = big_ff[k-1];
            trial    = {rem_prev[NW-2:0], 1'b0};
         end
      end

      always_comb begin
         take   = trial >= {1'b0, den_prev};
         rem_in = take ? trial - {1'b0, den_prev} : trial;
         q_in   = {q_prev[FW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            q_ff[k]   <= q_in;
            neg_ff[k] <= neg_prev;
            big_ff[k] <= big_prev;
         end
      end
   end

   always_comb begin
      if (neg_ff[S-1])
         quot = sbst_pkg::Q_NEG_SAT;
      else if (big_ff[S-1] || $signed({2'b00, q_ff[S-1]}) > sbst_pkg::Q_POS_SAT)
         quot = sbst_pkg::Q_POS_SAT;
      else
         quot = $signed({2'b00, q_ff[S-1]});
   end

endmodule

### rtl/core/sbst_axis.sv
module sbst_axis (
   input  logic                              clock,
   input  logic [sbst_pkg::DIV_STEPS:0]      en,
   input  logic signed [31:0]                box_min,
   input  logic signed [31:0]                box_max,
   input  logic signed [31:0]                start,
   input  logic signed [31:0]                stop,
   output sbst_pkg::axis_res_type            res
);

   localparam int unsigned S  = sbst_pkg::DIV_STEPS;
   localparam int unsigned NW = sbst_pkg::NUM_W;
   localparam int unsigned DW = sbst_pkg::DEN_W;

   logic signed [DW-1:0] d_w;
   logic signed [NW-1:0] a_w;
   logic signed [NW-1:0] b_w;
   logic signed [NW-1:0] d_neg_w;

   logic signed [NW-1:0] na_in, nb_in;
   logic [DW-1:0]        den_in;
   logic                 zero_in, inside_in;

   logic signed [NW-1:0] na_ff, nb_ff;
   logic [DW-1:0]        den_ff;
   logic                 zero_ff [S+1];
   logic                 inside_ff [S+1];

   always_comb begin
      d_w       = DW'(stop) - DW'(start);
      a_w       = NW'(box_min) - NW'(start);
      b_w       = NW'(box_max) - NW'(start);
      d_neg_w   = -NW'(d_w);
      zero_in   = d_w == '0;
      inside_in = (box_min <= start) && (start <= box_max);
      if (d_w[DW-1]) begin
         na_in  = -a_w;
         nb_in  = -b_w;
         den_in = d_neg_w[DW-1:0];
      end else begin
         na_in  = a_w;
         nb_in  = b_w;
         den_in = d_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         den_ff       <= den_in;
         zero_ff[0]   <= zero_in;
         inside_ff[0] <= inside_in;
      end
   end

   for (genvar k = 1; k <= S; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en[k]) begin
            zero_ff[k]   <= zero_ff[k-1];
            inside_ff[k] <= inside_ff[k-1];
         end
      end
   end

   sbst_div u_div_a (
      .clock (clock),
      .en    (en[S:1]),
      .num   (na_ff),
      .den   (den_ff),
      .quot  (res.qa)
   );

   sbst_div u_div_b (
      .clock (clock),
      .en    (en[S:1]),
      .num   (nb_ff),
      .den   (den_ff),
      .quot  (res.qb)
   );

   assign res.zero    = zero_ff[S];
   assign res.in_slab = inside_ff[S];

endmodule

### rtl/core/sbst_merge.sv
module sbst_merge (
   input  logic                                        clock,
   input  logic                                        en,
   input  sbst_pkg::axis_res_type [sbst_pkg::AXES-1:0] axis,
   output logic                                        hit,
   output logic [sbst_pkg::FRAC_W-1:0]                 entry_fraction,
   output logic [sbst_pkg::FRAC_W-1:0]                 exit_fraction
);

   localparam int unsigned QW = sbst_pkg::Q_W;
   localparam int unsigned FW = sbst_pkg::FRAC_W;

   logic signed [QW-1:0] lo, hi, qlo, qhi;
   logic                 ok;
   logic                 hit_in;
   logic [FW-1:0]        entry_in, exit_in;
   logic                 hit_ff;
   logic [FW-1:0]        entry_ff, exit_ff;

   always_comb begin
      lo = sbst_pkg::Q_ZERO;
      hi = sbst_pkg::Q_ONE;
      ok = 1'b1;
      for (int i = 0; i < int'(sbst_pkg::AXES); i++) begin
         qlo = (axis[i].qa > axis[i].qb) ? axis[i].qb : axis[i].qa;
         qhi = (axis[i].qa > axis[i].qb) ? axis[i].qa : axis[i].qb;
         if (axis[i].zero) begin
            if (!axis[i].in_slab)
               ok = 1'b0;
         end else begin
            if (qhi < lo || qlo > hi)
               ok = 1'b0;
            if (qlo > lo)
               lo = qlo;
            if (qhi < hi)
               hi = qhi;
            if (lo > hi)
               ok = 1'b0;
         end
      end
      hit_in = ok && (lo < sbst_pkg::Q_ONE);
      if (lo < sbst_pkg::Q_ZERO)
         entry_in = '0;
      else if (lo > sbst_pkg::Q_ONE)
         entry_in = sbst_pkg::FRAC_ONE;
      else
         entry_in = lo[FW-1:0];
      if (hi < sbst_pkg::Q_ZERO)
         exit_in = '0;
      else if (hi > sbst_pkg::Q_ONE)
         exit_in = sbst_pkg::FRAC_ONE;
      else
         exit_in = hi[FW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= hit_in;
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
      end
   end

   assign hit            = hit_ff;
   assign entry_fraction = entry_ff;
   assign exit_fraction  = exit_ff;

endmodule

### rtl/core/segment_box_slab_test_core.sv
// Segment versus axis-aligned box slab test. One item per cycle is taken while
// req_stall is low; each result passes through 19 register stages: an input stage,
// the 17-step restoring dividers (one quotient bit per stage) that each of the three
// axis lanes runs twice in parallel, and the merging output register. Stages advance
// independently, so bubbles close up and a stalled result does not block new
// transfers until the pipeline is full. Fractions are unsigned Q1.16; hit is 0 whenever
// any slab misses.
module segment_box_slab_test_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_box_min_x,
   input  logic signed [31:0]   req_box_min_y,
   input  logic signed [31:0]   req_box_min_z,
   input  logic signed [31:0]   req_box_max_x,
   input  logic signed [31:0]   req_box_max_y,
   input  logic signed [31:0]   req_box_max_z,
   input  logic signed [31:0]   req_start_x,
   input  logic signed [31:0]   req_start_y,
   input  logic signed [31:0]   req_start_z,
   input  logic signed [31:0]   req_end_x,
   input  logic signed [31:0]   req_end_y,
   input  logic signed [31:0]   req_end_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [16:0]          rsp_entry_fraction,
   output logic [16:0]          rsp_exit_fraction
);

   localparam int unsigned N = sbst_pkg::STAGES;

   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] en;

   sbst_pkg::axis_res_type [sbst_pkg::AXES-1:0] axis;

   always_comb begin
      en[N-1] = !valid_ff[N-1] || !rsp_stall;
      for (int i = N - 2; i >= 0; i--)
         en[i] = !valid_ff[i] || en[i+1];
      valid_in[0] = req_valid;
      for (int i = 1; i < N; i++)
         valid_in[i] = valid_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++)
            if (en[i])
               valid_ff[i] <= valid_in[i];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[N-1];

   sbst_axis u_axis_x (
      .clock   (clock),
      .en      (en[N-2:0]),
      .box_min (req_box_min_x),
      .box_max (req_box_max_x),
      .start   (req_start_x),
      .stop    (req_end_x),
      .res     (axis[0])
   );

   sbst_axis u_axis_y (
      .clock   (clock),
      .en      (en[N-2:0]),
      .box_min (req_box_min_y),
      .box_max (req_box_max_y),
      .start   (req_start_y),
      .stop    (req_end_y),
      .res     (axis[1])
   );

   sbst_axis u_axis_z (
      .clock   (clock),
      .en      (en[N-2:0]),
      .box_min (req_box_min_z),
      .box_max (req_box_max_z),
      .start   (req_start_z),
      .stop    (req_end_z),
      .res     (axis[2])
   );

   sbst_merge u_merge (
      .clock          (clock),
      .en             (en[N-1]),
      .axis           (axis),
      .hit            (rsp_hit),
      .entry_fraction (rsp_entry_fraction),
      .exit_fraction  (rsp_exit_fraction)
   );

endmodule

### rtl/core/sbst_checker.sv
module sbst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [16:0] rsp_entry_fraction,
   input logic [16:0] rsp_exit_fraction
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_entry_fraction) && $stable(rsp_exit_fraction))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_hit_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_entry_fraction < 17'h10000)
      else $error("hit with entry at one");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_entry_fraction <= rsp_exit_fraction)
      else $error("hit with entry past exit");

endmodule

bind segment_box_slab_test_core sbst_checker u_sbst_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_hit            (rsp_hit),
   .rsp_entry_fraction (rsp_entry_fraction),
   .rsp_exit_fraction  (rsp_exit_fraction)
);

### bench/segment_box_slab_test_core_tb.sv
module segment_box_slab_test_core_tb;

   localparam int CLOCK_PERIOD = 20;
   localparam int N_RANDOM     = 900;
   localparam int IDLE_LIMIT   = 20000;

   typedef struct {
      logic signed [31:0] bmin[3];
      logic signed [31:0] bmax[3];
      logic signed [31:0] sp[3];
      logic signed [31:0] ep[3];
   } segment_box_type;

   typedef struct {
      logic        hit;
      logic [16:0] entry;
      logic [16:0] exit_f;
   } slab_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   logic signed [31:0] req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic signed [31:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [31:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [16:0] rsp_entry_fraction, rsp_exit_fraction;

   segment_box_type  pending_items[$];
   slab_outcome_type expected_outcomes[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;
   bit  drain_pause = 1'b0;
   bit  req_taken = 1'b0;
   int  sent = 0;
   int  sender_gap = 0;
   int  receiver_gap = 0;
   int  long_hold_at = 300;

   segment_box_slab_test_core i_dut (.*);

   always #(CLOCK_PERIOD/2) clock = ~clock;

   function automatic longint floor_frac(longint num, longint den);
      longint n, q;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      n = num * 65536;
      if (n >= 0) q = n / den;
      else q = -((-n + den - 1) / den);
      if (q < -1) q = -1;
      if (q > 65537) q = 65537;
      return q;
   endfunction

   function automatic logic [16:0] clamp_frac(longint v);
      if (v < 0) return '0;
      if (v > 65536) return sbst_pkg::FRAC_ONE;
      return v[16:0];
   endfunction

   function automatic slab_outcome_type slab_intersect(segment_box_type it);
      longint lo, hi, bmn, bmx, s, d, qlo, qhi, t;
      bit ok;
      slab_outcome_type r;
      lo = 0;
      hi = 65536;
      ok = 1'b1;
      for (int ax = 0; ax < 3; ax++) begin
         bmn = it.bmin[ax];
         bmx = it.bmax[ax];
         s = it.sp[ax];
         d = longint'(it.ep[ax]) - s;
         if (d == 0) begin
            if (!(bmn <= s && s <= bmx)) ok = 1'b0;
            continue;
         end
         qlo = floor_frac(bmn - s, d);
         qhi = floor_frac(bmx - s, d);
         if (qlo > qhi) begin
            t = qlo;
            qlo = qhi;
            qhi = t;
         end
         if (qhi < lo || qlo > hi) ok = 1'b0;
         if (qlo > lo) lo = qlo;
         if (qhi < hi) hi = qhi;
         if (lo > hi) ok = 1'b0;
      end
      r.hit = ok && lo < 65536;
      r.entry = clamp_frac(lo);
      r.exit_f = clamp_frac(hi);
      return r;
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         3: return $signed($urandom_range(0, 8)) - 4;
         default: return ($signed($urandom_range(0, 2000)) - 1000) <<< 12;
      endcase
   endfunction

   function automatic segment_box_type random_item();
      segment_box_type it;
      logic signed [31:0] a, b;
      for (int ax = 0; ax < 3; ax++) begin
         a = pick_coord();
         b = pick_coord();
         if ($urandom_range(0, 9) != 0 && a > b) begin
            it.bmin[ax] = b;
            it.bmax[ax] = a;
         end else begin
            it.bmin[ax] = a;
            it.bmax[ax] = b;
         end
         it.sp[ax] = pick_coord();
         case ($urandom_range(0, 7))
            0: it.ep[ax] = it.sp[ax];
            1: it.ep[ax] = it.bmin[ax];
            2: it.ep[ax] = it.bmax[ax];
            default: it.ep[ax] = pick_coord();
         endcase
         if ($urandom_range(0, 5) == 0) it.sp[ax] = it.bmin[ax];
      end
      return it;
   endfunction

   function automatic segment_box_type uniform_item(logic signed [31:0] bmn,
                                                    logic signed [31:0] bmx,
                                                    logic signed [31:0] s,
                                                    logic signed [31:0] e);
      segment_box_type it;
      for (int ax = 0; ax < 3; ax++) begin
         it.bmin[ax] = bmn;
         it.bmax[ax] = bmx;
         it.sp[ax] = s;
         it.ep[ax] = e;
      end
      return it;
   endfunction

   task automatic load_directed();
      segment_box_type it;
      pending_items.push_back(uniform_item(-32'sd65536, 32'sd65536, -32'sd131072, 32'sd131072));
      pending_items.push_back(uniform_item(-32'sd65536, 32'sd65536, 32'sd131072, -32'sd131072));
      pending_items.push_back(uniform_item(-32'sd65536, 32'sd65536, 32'sd0, 32'sd0));
      pending_items.push_back(uniform_item(32'sd65536, -32'sd65536, 32'sd0, 32'sd0));
      pending_items.push_back(uniform_item(32'sd65536, -32'sd65536, -32'sd131072, 32'sd131072));
      pending_items.push_back(uniform_item(32'sd65536, 32'sd131072, 32'sd0, 32'sd65536));
      pending_items.push_back(uniform_item(-32'sd65536, 32'sd0, 32'sd0, 32'sd65536));
      pending_items.push_back(uniform_item(32'sd131072, 32'sd196608, 32'sd0, 32'sd65536));
      pending_items.push_back(uniform_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                           32'sh7fffffff));
      pending_items.push_back(uniform_item(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                           32'sh80000000));
      pending_items.push_back(uniform_item(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                                           32'sh7fffffff));
      pending_items.push_back(uniform_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                           32'sh80000000));
      pending_items.push_back(uniform_item(32'sd0, 32'sd1, 32'sd0, 32'sd3));
      pending_items.push_back(uniform_item(32'sd1, 32'sd2, 32'sd0, 32'sd3));
      pending_items.push_back(uniform_item(-32'sd1, 32'sd0, 32'sd0, 32'sh7fffffff));
      pending_items.push_back(uniform_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1));
      it = uniform_item(-32'sd65536, 32'sd65536, 32'sd0, 32'sd0);
      it.ep[0] = 32'sd262144;
      pending_items.push_back(it);
      it.sp[1] = 32'sd196608;
      it.ep[1] = 32'sd196608;
      pending_items.push_back(it);
      it = uniform_item(32'sd0, 32'sd65536, -32'sd65536, 32'sd131072);
      it.sp[2] = 32'sd131072;
      it.ep[2] = -32'sd65536;
      it.bmin[1] = 32'sd98304;
      pending_items.push_back(it);
   endtask

   initial begin
      load_directed();
      for (int i = 0; i < N_RANDOM; i++) pending_items.push_back(random_item());
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (drain_pause) begin
            req_valid <= 1'b0;
            if (expected_outcomes.size() == 0) drain_pause <= 1'b0;
         end else if (!req_valid || req_taken) begin
            if (req_taken && sent == 600) begin
               req_valid <= 1'b0;
               drain_pause <= 1'b1;
            end else if (sender_gap > 0) begin
               req_valid <= 1'b0;
               sender_gap <= sender_gap - 1;
            end else if (pending_items.size() > 0) begin
               segment_box_type it;
               it = pending_items[0];
               req_valid <= 1'b1;
               req_box_min_x <= it.bmin[0];
               req_box_min_y <= it.bmin[1];
               req_box_min_z <= it.bmin[2];
               req_box_max_x <= it.bmax[0];
               req_box_max_y <= it.bmax[1];
               req_box_max_z <= it.bmax[2];
               req_start_x <= it.sp[0];
               req_start_y <= it.sp[1];
               req_start_z <= it.sp[2];
               req_end_x <= it.ep[0];
               req_end_y <= it.ep[1];
               req_end_z <= it.ep[2];
               if (sent > 100 && $urandom_range(0, 3) == 0)
                  sender_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                           : $urandom_range(0, 2);
            end else begin
               req_valid <= 1'b0;
               stimulus_done <= 1'b1;
            end
         end
         if (long_hold_at >= 0 && sent >= long_hold_at && receiver_gap == 0) begin
            receiver_gap <= 200;
            long_hold_at <= -1000;
            rsp_stall <= 1'b1;
         end else if (receiver_gap > 0) begin
            receiver_gap <= receiver_gap - 1;
            rsp_stall <= 1'b1;
         end else if (sent > 50 && $urandom_range(0, 4) == 0) begin
            receiver_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      slab_outcome_type want;
      bit moved;
      moved = 1'b0;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_taken) begin
            segment_box_type it;
            it = pending_items.pop_front();
            expected_outcomes.push_back(slab_intersect(it));
            sent <= sent + 1;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_outcomes.size() == 0) begin
               $error("unexpected transfer on rsp");
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit expected %0d actual %0d", want.hit, rsp_hit);
                  errors++;
               end
               if (rsp_entry_fraction !== want.entry) begin
                  $error("entry_fraction expected %0d actual %0d", want.entry,
                         rsp_entry_fraction);
                  errors++;
               end
               if (rsp_exit_fraction !== want.exit_f) begin
                  $error("exit_fraction expected %0d actual %0d", want.exit_f,
                         rsp_exit_fraction);
                  errors++;
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      wait (!reset);
      fork
         begin
            wait (stimulus_done && expected_outcomes.size() == 0);
            repeat (sbst_pkg::STAGES + 10) @(posedge clock);
         end
         wait (idle_cycles >= IDLE_LIMIT);
      join_any
      if (idle_cycles >= IDLE_LIMIT || errors != 0) begin
         $display("segment_box_slab_test_core_tb failed");
      end else begin
         $display("segment_box_slab_test_core_tb passed");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/sbst_pkg.sv
rtl/core/sbst_div.sv
rtl/core/sbst_axis.sv
rtl/core/sbst_merge.sv
rtl/core/segment_box_slab_test_core.sv
rtl/core/sbst_checker.sv
bench/segment_box_slab_test_core_tb.sv
